// ===== hw/rtl/prfa_pkg.sv =====
// Shared types and constants for the paired resource FIFO arbiter.
// No dependencies; imported by every module of the block.
`default_nettype none

package prfa_pkg;

    // Fixed field widths of the block's ports.
    localparam int SEAT_W  = 4;
    localparam int COUNT_W = 5;

    // At most this many grants are issued for one input transfer.
    localparam int GRANT_LIMIT = 8;
    localparam int GRANT_W     = $clog2(GRANT_LIMIT + 1);
    localparam int EMIT_W      = $clog2(GRANT_LIMIT);

    // Operation codes carried by the opcode field.
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RETURN  = 1'b1;

    // Reset value of the seat count register.
    localparam logic [COUNT_W-1:0] SEAT_COUNT_RESET = 5'd5;

    typedef logic [SEAT_W-1:0]  t_seat;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

`default_nettype wire

// ===== hw/rtl/prfa_wait_queue.sv =====
// Storage for the wait queue: one write port and one read port with registered data.
// Depends on prfa_pkg for the seat type.
`default_nettype none

module prfa_wait_queue #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  prfa_pkg::t_seat    i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output prfa_pkg::t_seat    o_rdata
);
    import prfa_pkg::*;

    t_seat r_mem [DEPTH];
    t_seat r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/paired_resource_fifo_arbiter.sv =====
// Top level of the paired resource FIFO arbiter: sequencer, resource flags and result list.
// Depends on prfa_pkg and instantiates prfa_wait_queue.
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+----------------------------------------
// input     | in        | i_in_valid / o_in_ready    | i_opcode, i_seat_id
// result    | out       | o_out_valid / i_out_ready  | o_grant_valid, o_granted_seat,
//           |           |                            | o_request_dropped, o_last
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_seat_count
//
// An input transfer is accepted in the idle state, then the scan reads the whole queue as it
// stands after the request or return is applied, then the results follow (one per grant, or
// a single empty result). The scan is set by the wait queue's single read port: one queued
// entry is evaluated per cycle. The block takes one item at a time; o_in_ready is high only
// between items. Stalls on the result side hold the current result and freeze the sequencer.
// Reset is synchronous and active low; it frees every resource, empties the queue and loads
// the seat count with 5. The queue storage itself needs no clearing pass.

module paired_resource_fifo_arbiter #(
    parameter int MAX_SEATS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  prfa_pkg::t_seat   i_seat_id,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_grant_valid,
    output prfa_pkg::t_seat   o_granted_seat,
    output logic              o_request_dropped,
    output logic              o_last,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  prfa_pkg::t_count  i_cfg_seat_count
);
    import prfa_pkg::*;

    // Address of a queue entry or a resource flag.
    localparam int AW = $clog2(MAX_SEATS);
    // Queue length, which can reach MAX_SEATS itself.
    localparam int QW = $clog2(MAX_SEATS + 1);
    // Width for seat and seat count arithmetic; holds the active seat count and seat + 1.
    localparam int NW = (QW > COUNT_W) ? QW : COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Right-hand neighbor of a seat, wrapping to seat 0 at the active seat count.
    function automatic logic [NW-1:0] right_of(input logic [NW-1:0] seat,
                                               input logic [NW-1:0] n);
        logic [NW-1:0] nxt;
        nxt = seat + NW'(1);
        return (nxt >= n) ? '0 : nxt;
    endfunction

    logic [1:0]            r_state,     n_state;
    t_count                r_seat_count;
    logic [MAX_SEATS-1:0]  r_free,      n_free;
    logic [QW-1:0]         r_qlen,      n_qlen;
    logic                  r_drop,      n_drop;
    logic [QW-1:0]         r_rd_idx,    n_rd_idx;
    logic [QW-1:0]         r_keep,      n_keep;
    logic                  r_ev_vld,    n_ev_vld;
    logic [GRANT_W-1:0]    r_grants,    n_grants;
    t_seat                 r_list [GRANT_LIMIT];
    t_seat                 n_list [GRANT_LIMIT];
    logic [EMIT_W-1:0]     r_emit_idx,  n_emit_idx;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    t_seat                 mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    t_seat                 mem_rdata;

    logic [NW-1:0]         sc_x;
    logic [NW-1:0]         active_n;
    logic                  in_xfer;
    logic                  out_xfer;
    logic [NW-1:0]         id_x;
    logic [NW-1:0]         id_r;
    logic                  id_in;
    logic                  q_full;
    logic [NW-1:0]         ev_x;
    logic [NW-1:0]         ev_r;
    logic                  ev_ok;
    logic                  rd_more;
    logic                  scan_done;
    logic [GRANT_W-1:0]    emit_cnt;

    prfa_wait_queue #(
        .DEPTH  (MAX_SEATS),
        .ADDR_W (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Seat count in use: zero behaves as one, and values above MAX_SEATS are clipped.
    assign sc_x     = NW'(r_seat_count);
    assign active_n = (r_seat_count == '0)      ? NW'(1)
                    : (sc_x > NW'(MAX_SEATS))   ? NW'(MAX_SEATS)
                    : sc_x;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    assign id_x   = NW'(i_seat_id);
    assign id_in  = (id_x < active_n);
    assign id_r   = right_of(id_x, active_n);
    assign q_full = (r_qlen >= QW'(MAX_SEATS));

    // Evaluation of the entry whose read data arrived this cycle. A seat at or above the
    // active count is stale and is kept in the queue untouched.
    assign ev_x  = NW'(mem_rdata);
    assign ev_r  = right_of(ev_x, active_n);
    assign ev_ok = r_ev_vld && (r_grants < GRANT_W'(GRANT_LIMIT)) && (ev_x < active_n)
                && r_free[ev_x[AW-1:0]] && r_free[ev_r[AW-1:0]];

    // The scan ends in the cycle that evaluates the last entry, or at once on an empty queue.
    assign rd_more   = (r_rd_idx < r_qlen);
    assign scan_done = !rd_more;

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_qlen     = r_qlen;
        n_drop     = r_drop;
        n_rd_idx   = r_rd_idx;
        n_keep     = r_keep;
        n_ev_vld   = r_ev_vld;
        n_grants   = r_grants;
        n_list     = r_list;
        n_emit_idx = r_emit_idx;
        mem_we     = 1'b0;
        mem_waddr  = r_qlen[AW-1:0];
        mem_wdata  = i_seat_id;
        mem_re     = 1'b0;
        mem_raddr  = r_rd_idx[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_drop = 1'b0;
                    if (i_opcode == OP_REQUEST) begin
                        if (!id_in || q_full) begin
                            n_drop = 1'b1;
                        end else begin
                            // Append at the tail.
                            mem_we = 1'b1;
                            n_qlen = r_qlen + QW'(1);
                        end
                    end else if (id_in) begin
                        n_free[id_x[AW-1:0]] = 1'b1;
                        n_free[id_r[AW-1:0]] = 1'b1;
                    end
                    n_rd_idx = '0;
                    n_keep   = '0;
                    n_ev_vld = 1'b0;
                    n_grants = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Read one entry ahead while evaluating the previous one. The write side
                // compacts survivors toward the head; its address never passes the read side.
                mem_re   = rd_more;
                n_ev_vld = rd_more;
                if (rd_more) begin
                    n_rd_idx = r_rd_idx + QW'(1);
                end
                if (r_ev_vld) begin
                    if (ev_ok) begin
                        n_free[ev_x[AW-1:0]]          = 1'b0;
                        n_free[ev_r[AW-1:0]]          = 1'b0;
                        n_list[r_grants[EMIT_W-1:0]]  = mem_rdata;
                        n_grants                      = r_grants + GRANT_W'(1);
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_keep[AW-1:0];
                        mem_wdata = mem_rdata;
                        n_keep    = r_keep + QW'(1);
                    end
                end
                if (scan_done) begin
                    n_qlen     = n_keep;
                    n_emit_idx = '0;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    if (o_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + EMIT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seat_count <= SEAT_COUNT_RESET;
            r_free       <= '1;
            r_qlen       <= '0;
            r_drop       <= 1'b0;
            r_rd_idx     <= '0;
            r_keep       <= '0;
            r_ev_vld     <= 1'b0;
            r_grants     <= '0;
            r_emit_idx   <= '0;
        end else begin
            r_state    <= n_state;
            r_free     <= n_free;
            r_qlen     <= n_qlen;
            r_drop     <= n_drop;
            r_rd_idx   <= n_rd_idx;
            r_keep     <= n_keep;
            r_ev_vld   <= n_ev_vld;
            r_grants   <= n_grants;
            r_emit_idx <= n_emit_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seat_count <= i_cfg_seat_count;
            end
        end
    end

    // The granted seats carry no reset; only entries below the grant count are ever shown.
    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

    // Results: one per grant in queue order, or a single empty result when nothing was granted.
    assign emit_cnt          = (r_grants == '0) ? GRANT_W'(1) : r_grants;
    assign o_out_valid       = (r_state == ST_EMIT);
    assign o_grant_valid     = (r_grants != '0);
    assign o_granted_seat    = (r_grants != '0) ? r_list[r_emit_idx] : '0;
    assign o_request_dropped = r_drop;
    assign o_last            = ((GRANT_W'(r_emit_idx) + GRANT_W'(1)) == emit_cnt);

    // The queue never holds more entries than it has room for.
    a_qlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= QW'(MAX_SEATS))
        else $error("wait queue length exceeds its depth");

    // Compaction writes never overtake the read pointer.
    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_keep <= r_rd_idx))
        else $error("compaction pointer passed the read pointer");

    // The grant count stays within the result list.
    a_grant_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grants <= GRANT_W'(GRANT_LIMIT))
        else $error("grant count exceeds the result list");

    // After the final result of an item is taken, the block is ready for the next item.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_last) |=> o_in_ready)
        else $error("block not ready after the final result");

endmodule

`default_nettype wire
